@@ sv/led_dimmer_fade_delay_off_top_defines.svh @@
// Assertion macros used by the dimmer top level.
`ifndef LED_DIMMER_FADE_DELAY_OFF_TOP_DEFINES_SVH
`define LED_DIMMER_FADE_DELAY_OFF_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LDFD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dimmer assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define LDFD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dimmer assertion failed one cycle later");

`endif

@@ sv/ldfd_pkg.sv @@
package ldfd_pkg;

   localparam int LEVEL_W = 8;
   localparam int CODE_W  = 8;
   localparam int CMD_W   = 2;
   localparam int CSR_IDX_W = 1;
   localparam int RSP_DATA_W = 16;

   // Event kinds carried with each item.
   localparam logic [CMD_W-1:0] CMD_RADIO = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FADE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LONG  = 2'd2;

   // Radio command codes.
   localparam logic [CODE_W-1:0] CODE_LEVEL_LAST = 8'd10;
   localparam logic [CODE_W-1:0] CODE_DELAY_OFF  = 8'd20;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_OFF_LIMIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_LENGTH    = 1'd1;

   // Reset values.
   localparam logic [LEVEL_W-1:0] DELAY_OFF_LIMIT_RST = 8'd12;
   localparam logic [LEVEL_W-1:0] BLINK_LENGTH_RST    = 8'd10;
   localparam logic [LEVEL_W-1:0] TARGET_RST          = 8'd255;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [CODE_W-1:0] command_code;
   } item_type;

   typedef struct packed {
      logic                blinking;
      logic                fading;
      logic                delay_off_active;
      logic [LEVEL_W-1:0]  duty_level;
   } result_type;

   // Brightness steps selected by radio codes 0 to 10.
   function automatic logic [LEVEL_W-1:0] level_lookup(input logic [CODE_W-1:0] code);
      logic [LEVEL_W-1:0] lvl;
      case (code)
         8'd0:    lvl = 8'd0;
         8'd1:    lvl = 8'd3;
         8'd2:    lvl = 8'd8;
         8'd3:    lvl = 8'd16;
         8'd4:    lvl = 8'd30;
         8'd5:    lvl = 8'd50;
         8'd6:    lvl = 8'd75;
         8'd7:    lvl = 8'd100;
         8'd8:    lvl = 8'd140;
         8'd9:    lvl = 8'd190;
         8'd10:   lvl = 8'd255;
         default: lvl = 8'd0;
      endcase
      return lvl;
   endfunction

endpackage

@@ sv/led_dimmer_fade_delay_off_top.sv @@
// Channel   Direction  Payload
// req_      in         tuser = cmd, tdata = command_code
// rsp_      out        tdata = duty_level, delay_off_active, fading, blinking
// csr_      in         write enable, register index, 8-bit write data
//
// Each transfer on req_ produces exactly one transfer on rsp_, held first in the input
// register and then in the result register. One item is taken every cycle while rsp_
// is not stalled; the rate is set by the single update stage between them.
// Reset is synchronous and active high; it restores the level, mode and counters
// and the two configuration registers. A stall on rsp_ holds the result register,
// and req_tready drops only when both the input and result registers are full.
`include "led_dimmer_fade_delay_off_top_defines.svh"

module led_dimmer_fade_delay_off_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   input  logic [7:0]  req_tdata,   // [7:0] command_code
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] duty_level, [8] delay_off_active,
                                    // [9] fading, [10] blinking, rest zero
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   logic                 item_valid;
   ldfd_pkg::item_type   item;
   ldfd_pkg::result_type result;
   logic                 advance;
   logic                 update;

   // The input register moves on whenever the result register is empty or
   // being emptied in this cycle.
   assign advance = !rsp_tvalid || rsp_tready;
   assign update  = item_valid && advance;

   ldfd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // The dimmer state commits in the same cycle the result is loaded, so the
   // result always reflects the state after that item.
   ldfd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .update    (update),
      .item      (item),
      .result    (result)
   );

   ldfd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (update),
      .result     (result),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // A blinking result always shows a dark lamp.
   `LDFD_ASSERT_NOW(a_blink_dark, clock, reset, rsp_tvalid && rsp_tdata[10], rsp_tdata[7:0] == 8'd0)
   // A result appears only when an item left the input register.
   `LDFD_ASSERT_NEXT(a_result_source, clock, reset, !rsp_tvalid && !item_valid, !rsp_tvalid)
   // No new item is taken while both registers are full and the output is stalled.
   `LDFD_ASSERT_NOW(a_no_overrun, clock, reset, item_valid && rsp_tvalid && !rsp_tready, !req_tready)

endmodule

@@ sv/ldfd_in_stage.sv @@
module ldfd_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           req_tuser,
   input  logic [7:0]           req_tdata,
   input  logic                 advance,
   output logic                 item_valid,
   output ldfd_pkg::item_type   item
);

   logic               valid_ff, valid_in;
   ldfd_pkg::item_type item_ff;
   logic               take;

   // The register may refill in the same cycle it hands its item on.
   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.cmd          <= req_tuser;
         item_ff.command_code <= req_tdata;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ sv/ldfd_core.sv @@
module ldfd_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [0:0]           csr_index,
   input  logic [7:0]           csr_wdata,
   input  logic                 update,
   input  ldfd_pkg::item_type   item,
   output ldfd_pkg::result_type result
);

   logic [7:0] limit_ff, blink_len_ff;
   logic [7:0] current_ff, current_in;
   logic [7:0] target_ff, target_in;
   logic       mode_ff, mode_in;
   logic [7:0] dcount_ff, dcount_in;
   logic [7:0] bcount_ff, bcount_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= ldfd_pkg::DELAY_OFF_LIMIT_RST;
         blink_len_ff <= ldfd_pkg::BLINK_LENGTH_RST;
      end else if (csr_we) begin
         case (csr_index)
            ldfd_pkg::CSR_DELAY_OFF_LIMIT: limit_ff     <= csr_wdata;
            ldfd_pkg::CSR_BLINK_LENGTH:    blink_len_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      current_in = current_ff;
      target_in  = target_ff;
      mode_in    = mode_ff;
      dcount_in  = dcount_ff;
      bcount_in  = bcount_ff;
      case (item.cmd)
         ldfd_pkg::CMD_RADIO: begin
            if (item.command_code <= ldfd_pkg::CODE_LEVEL_LAST) begin
               target_in = ldfd_pkg::level_lookup(item.command_code);
               mode_in   = 1'b0;
            end else if (item.command_code == ldfd_pkg::CODE_DELAY_OFF) begin
               bcount_in = blink_len_ff;
               mode_in   = 1'b1;
               dcount_in = 8'd0;
            end
         end
         ldfd_pkg::CMD_FADE: begin
            // A running blink holds the fade and only counts down.
            if (bcount_ff != 8'd0) begin
               bcount_in = 8'(bcount_ff - 8'd1);
            end else if (current_ff < target_ff) begin
               current_in = 8'(current_ff + 8'd1);
            end else if (current_ff > target_ff) begin
               current_in = 8'(current_ff - 8'd1);
            end
         end
         ldfd_pkg::CMD_LONG: begin
            if (mode_ff && current_ff != 8'd0) begin
               if (dcount_ff < limit_ff) begin
                  dcount_in = 8'(dcount_ff + 8'd1);
               end else begin
                  target_in = 8'd0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_ff <= 8'd0;
         target_ff  <= ldfd_pkg::TARGET_RST;
         mode_ff    <= 1'b0;
         dcount_ff  <= 8'd0;
         bcount_ff  <= 8'd0;
      end else if (update) begin
         current_ff <= current_in;
         target_ff  <= target_in;
         mode_ff    <= mode_in;
         dcount_ff  <= dcount_in;
         bcount_ff  <= bcount_in;
      end
   end

   always_comb begin
      result.blinking         = (bcount_in != 8'd0);
      result.fading           = (current_in != target_in);
      result.delay_off_active = mode_in;
      result.duty_level       = (bcount_in != 8'd0) ? 8'd0 : current_in;
   end

endmodule

@@ sv/ldfd_out_stage.sv @@
module ldfd_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  ldfd_pkg::result_type result,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata
);

   logic                 valid_ff, valid_in;
   ldfd_pkg::result_type data_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'd0, data_ff};

endmodule
